// File: hw/rtl/ahs_pkg.sv
package ahs_pkg;

	// Default sizes.
	localparam int LEVEL_COUNT_DEF = 256;
	localparam int COORD_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int LEVEL_W = 8;
	localparam int COORD_W = 16;
	localparam int VAL_W   = 16;
	localparam int PIX_W   = 8;

	// Q8.8 to Q.14 shift.
	localparam int Q14_SHIFT = 6;
	localparam int Q14_W     = VAL_W + Q14_SHIFT;

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

	// Function codes of an input beat.
	localparam logic FUNC_SCREEN = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_COS    = 2'd0,
		CFG_SIN    = 2'd1,
		CFG_RADIUS = 2'd2,
		CFG_PERIOD = 2'd3
	} cfg_idx_t;

	localparam logic [VAL_W-1:0] COS_RST    = 16'd16384;
	localparam logic [VAL_W-1:0] SIN_RST    = 16'd0;
	localparam logic [VAL_W-1:0] RADIUS_RST = 16'd512;
	localparam logic [VAL_W-1:0] PERIOD_RST = 16'd1024;

	// Side information travelling with a pixel down the pipeline.
	typedef struct packed {
		logic                 valid;
		logic                 zero_p;
		logic [VAL_W-1:0]     ds;
		logic                 neg_u;
		logic                 neg_v;
		logic [Q14_SHIFT-1:0] low_u;
		logic [Q14_SHIFT-1:0] low_v;
	} sb_t;

	// One restoring step of the remainder: shift in a bit, subtract if it fits.
	function automatic logic [VAL_W-1:0] mod_step(input logic [VAL_W-1:0] rem,
			input logic din, input logic [VAL_W-1:0] per);
		logic [VAL_W:0] trial;
		trial = {rem, din};
		if (trial >= {1'b0, per}) begin
			mod_step = VAL_W'(trial - {1'b0, per});
		end else begin
			mod_step = trial[VAL_W-1:0];
		end
	endfunction

endpackage

// File: hw/rtl/ahs_table.sv
module ahs_table import ahs_pkg::*; #(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(LEVEL_COUNT)-1:0] wr_addr,
	input  logic [VAL_W-1:0]               wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(LEVEL_COUNT)-1:0] rd_addr,
	output logic [VAL_W-1:0]               rd_data
);

	logic [VAL_W-1:0] mem [LEVEL_COUNT];
	logic [VAL_W-1:0] rd_q;

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: hw/rtl/ahs_rotate.sv
module ahs_rotate import ahs_pkg::*; #(
	parameter int CW = COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  logic                     in_range,
	input  logic [CW-1:0]            x,
	input  logic [CW-1:0]            y,
	input  logic signed [VAL_W-1:0]  cos_a,
	input  logic signed [VAL_W-1:0]  sin_a,
	input  logic [VAL_W-1:0]         radius,
	input  logic [VAL_W-1:0]         period,
	input  logic [VAL_W-1:0]         ds,
	output logic [CW+10:0]           nu,
	output logic [CW+10:0]           nv,
	output sb_t                      sb
);

	localparam int SW = CW + 18;
	localparam int MW = CW + 17;
	localparam int PW = CW + 17;

	logic signed [PW-1:0] xc_s1, xs_s1, yc_s1, ys_s1;
	logic                 valid_s1, in_range_s1, zero_p_s1;
	logic signed [CW:0]   xe, ye;
	logic signed [SW-1:0] u, v, r14;
	logic [MW-1:0]        mag_u, mag_v;
	logic [MW-1:0]        mag_u_s2, mag_v_s2;
	sb_t                  sb_s2;

	assign xe = signed'({1'b0, x});
	assign ye = signed'({1'b0, y});

	// Stage one: the four rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1 <= xe * cos_a;
			xs_s1 <= xe * sin_a;
			yc_s1 <= ye * cos_a;
			ys_s1 <= ye * sin_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			in_range_s1 <= 1'b0;
			zero_p_s1   <= 1'b0;
		end else if (en) begin
			valid_s1    <= valid;
			in_range_s1 <= in_range;
			zero_p_s1   <= (period == '0);
		end
	end

	// Stage two: offset sums and their magnitudes.
	always_comb begin
		r14   = signed'(SW'({radius, {Q14_SHIFT{1'b0}}}));
		u     = SW'(xc_s1) - SW'(ys_s1) + r14;
		v     = SW'(xs_s1) + SW'(yc_s1) + r14;
		mag_u = u[SW-1] ? MW'(-u) : MW'(u);
		mag_v = v[SW-1] ? MW'(-v) : MW'(v);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_u_s2 <= mag_u;
			mag_v_s2 <= mag_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s2 <= '0;
		end else if (en) begin
			sb_s2.valid  <= valid_s1;
			sb_s2.zero_p <= zero_p_s1;
			sb_s2.ds     <= in_range_s1 ? ds : '0;
			sb_s2.neg_u  <= u[SW-1];
			sb_s2.neg_v  <= v[SW-1];
			sb_s2.low_u  <= mag_u[Q14_SHIFT-1:0];
			sb_s2.low_v  <= mag_v[Q14_SHIFT-1:0];
		end
	end

	assign nu = mag_u_s2[MW-1:Q14_SHIFT];
	assign nv = mag_v_s2[MW-1:Q14_SHIFT];
	assign sb = sb_s2;

endmodule

// File: hw/rtl/ahs_mod_pipe.sv
module ahs_mod_pipe import ahs_pkg::*; #(
	parameter int NW = COORD_BITS_DEF + 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [VAL_W-1:0] period,
	input  logic [NW-1:0]    nu,
	input  logic [NW-1:0]    nv,
	input  sb_t              sb_in,
	output logic [VAL_W-1:0] rem_u,
	output logic [VAL_W-1:0] rem_v,
	output sb_t              sb_out
);

	logic [VAL_W-1:0] ru_q [NW];
	logic [VAL_W-1:0] rv_q [NW];
	logic [NW-1:0]    nu_q [NW];
	logic [NW-1:0]    nv_q [NW];
	sb_t              sb_q [NW];

	// One quotient bit per stage, most significant first, both lanes at once.
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [VAL_W-1:0] ru_prev, rv_prev;
		logic [NW-1:0]    nu_prev, nv_prev;
		sb_t              sb_prev;

		if (k == 0) begin : g_first
			assign ru_prev = '0;
			assign rv_prev = '0;
			assign nu_prev = nu;
			assign nv_prev = nv;
			assign sb_prev = sb_in;
		end else begin : g_next
			assign ru_prev = ru_q[k-1];
			assign rv_prev = rv_q[k-1];
			assign nu_prev = nu_q[k-1];
			assign nv_prev = nv_q[k-1];
			assign sb_prev = sb_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ru_q[k] <= mod_step(ru_prev, nu_prev[NW-1-k], period);
				rv_q[k] <= mod_step(rv_prev, nv_prev[NW-1-k], period);
				nu_q[k] <= nu_prev;
				nv_q[k] <= nv_prev;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_q[k] <= '0;
			end else if (en) begin
				sb_q[k] <= sb_prev;
			end
		end
	end

	assign rem_u  = ru_q[NW-1];
	assign rem_v  = rv_q[NW-1];
	assign sb_out = sb_q[NW-1];

endmodule

// File: hw/rtl/ahs_dist.sv
module ahs_dist import ahs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [VAL_W-1:0] period,
	input  logic [VAL_W-1:0] radius,
	input  logic [VAL_W-1:0] rem_u,
	input  logic [VAL_W-1:0] rem_v,
	input  sb_t              sb,
	output logic             pix_valid,
	output logic [PIX_W-1:0] pix
);

	localparam int DW = Q14_W + 2;

	logic [Q14_W-1:0]      p14, r14, ru, rv, wu, wv;
	logic signed [DW-1:0]  dx, dy;
	logic signed [DW-1:0]  dx_sa, dy_sa;
	logic [Q14_W-1:0]      ds_sa;
	logic                  valid_sa, zero_sa;
	logic [2*DW-1:0]       dx2_sb, dy2_sb;
	logic [2*Q14_W-1:0]    ds2_sb;
	logic                  valid_sb, zero_sb;
	logic [2*DW:0]         dist2;
	logic                  valid_q;
	logic [PIX_W-1:0]      pix_q;

	// Positive remainder and re-centring on the cell.
	always_comb begin
		p14 = {period, {Q14_SHIFT{1'b0}}};
		r14 = {radius, {Q14_SHIFT{1'b0}}};
		ru  = {rem_u, sb.low_u};
		rv  = {rem_v, sb.low_v};
		wu  = (sb.neg_u && ru != '0) ? p14 - ru : ru;
		wv  = (sb.neg_v && rv != '0) ? p14 - rv : rv;
		dx  = signed'({2'b00, wu}) - signed'({2'b00, r14});
		dy  = signed'({2'b00, wv}) - signed'({2'b00, r14});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_sa <= dx;
			dy_sa <= dy;
			ds_sa <= {sb.ds, {Q14_SHIFT{1'b0}}};
		end
	end

	// Squares.
	always_ff @(posedge clk) begin
		if (en) begin
			dx2_sb <= (2*DW)'(dx_sa * dx_sa);
			dy2_sb <= (2*DW)'(dy_sa * dy_sa);
			ds2_sb <= ds_sa * ds_sa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
			zero_sa  <= 1'b0;
			valid_sb <= 1'b0;
			zero_sb  <= 1'b0;
		end else if (en) begin
			valid_sa <= sb.valid;
			zero_sa  <= sb.zero_p;
			valid_sb <= valid_sa;
			zero_sb  <= zero_sa;
		end
	end

	// Compare and output register.
	assign dist2 = {1'b0, dx2_sb} + {1'b0, dy2_sb};

	always_ff @(posedge clk) begin
		if (en) begin
			pix_q <= (!zero_sb && dist2 <= (2*DW+1)'(ds2_sb)) ? PIX_WHITE : PIX_BLACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_sb;
		end
	end

	assign pix_valid = valid_q;
	assign pix       = pix_q;

endmodule

// File: hw/rtl/am_halftone_screen_core.sv
// Channel  | Direction | Handshake             | Beat contents
// in       | input     | in_valid / in_stall   | func, level, x_pos, y_pos, entry_value
// out      | output    | out_valid / out_stall | pixel_out
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat is accepted every cycle unless in_stall is high; a pixel result leaves after
// the rotation stages, the one-bit-per-stage remainder pipeline and the distance stages.
// Reset clears the pipeline valid bits and loads the register defaults; the
// dot size table is not cleared and must be loaded before use.
// A stalled output beat holds the whole pipeline, and in_stall follows it.
module am_halftone_screen_core import ahs_pkg::*; #(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [LEVEL_W-1:0] level,
	input  logic [COORD_W-1:0] x_pos,
	input  logic [COORD_W-1:0] y_pos,
	input  logic [VAL_W-1:0]   entry_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIX_W-1:0]   pixel_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [VAL_W-1:0]   cfg_data
);

	localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int NW = CW + 11;
	localparam int IW = $clog2(LEVEL_COUNT);

	logic              adv, accept, in_range;
	logic [10:0]       level_ext;
	logic [VAL_W-1:0]  cos_q, sin_q, radius_q, period_q;
	logic [VAL_W-1:0]  ds_rd, rem_u, rem_v;
	logic [NW-1:0]     nu, nv;
	sb_t               sb_rot, sb_mod;

	// Pipeline advances unless the output beat is held.
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;
	assign cfg_ready = 1'b1;

	assign level_ext = 11'(level);
	assign in_range  = level_ext < 11'(LEVEL_COUNT);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RST;
			sin_q    <= SIN_RST;
			radius_q <= RADIUS_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_COS:    cos_q    <= cfg_data;
				CFG_SIN:    sin_q    <= cfg_data;
				CFG_RADIUS: radius_q <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data;
			endcase
		end
	end

	// Dot size table: loads write at acceptance, pixels read alongside.
	ahs_table #(.LEVEL_COUNT(LEVEL_COUNT)) u_table (
		.clk     (clk),
		.wr_en   (accept && func == FUNC_LOAD && in_range),
		.wr_addr (level_ext[IW-1:0]),
		.wr_data (entry_value),
		.rd_en   (adv),
		.rd_addr (level_ext[IW-1:0]),
		.rd_data (ds_rd)
	);

	ahs_rotate #(.CW(CW)) u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.valid    (accept && func == FUNC_SCREEN),
		.in_range (in_range),
		.x        (x_pos[CW-1:0]),
		.y        (y_pos[CW-1:0]),
		.cos_a    (signed'(cos_q)),
		.sin_a    (signed'(sin_q)),
		.radius   (radius_q),
		.period   (period_q),
		.ds       (ds_rd),
		.nu       (nu),
		.nv       (nv),
		.sb       (sb_rot)
	);

	ahs_mod_pipe #(.NW(NW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.period (period_q),
		.nu     (nu),
		.nv     (nv),
		.sb_in  (sb_rot),
		.rem_u  (rem_u),
		.rem_v  (rem_v),
		.sb_out (sb_mod)
	);

	ahs_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.period    (period_q),
		.radius    (radius_q),
		.rem_u     (rem_u),
		.rem_v     (rem_v),
		.sb        (sb_mod),
		.pix_valid (out_valid),
		.pix       (pixel_out)
	);

endmodule
